[design/msmj_pkg.sv]
// Shared types and constants of the multiway sort-merge join block.
// Used by the channel interface, the controller, the datapath and the top level.
// Depends on nothing.
`default_nettype none

package msmj_pkg;

  // Item modes.
  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD_R = 2'd1;
  localparam logic [1:0] MODE_LOAD_S = 2'd2;
  localparam logic [1:0] MODE_PULL = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PAIR = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_R_RUN_COUNT = 3'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_S_RUN_COUNT = 3'h4;

  // Relation select.
  localparam logic SIDE_R = 1'b0;
  localparam logic SIDE_S = 1'b1;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] run_index;
    logic signed [31:0] tuple_key;
    logic signed [31:0] tuple_payload;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] r_key;
    logic signed [31:0] r_value;
    logic signed [31:0] s_key;
    logic signed [31:0] s_value;
  } result_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] val;
  } tuple_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clear;
    logic load_r;
    logic load_s;
    logic side;
    logic rd_head;
    logic run_rst;
    logic run_inc;
    logic min_init;
    logic min_upd;
    logic pos_inc;
    logic grp_start;
    logic grp_push;
    logic grp_set;
    logic grp_rd;
    logic grp_end;
    logic emit_pair;
    logic res_done;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic group_active;
    logic run_lt_n;
    logic head_valid;
    logic key_eq_group;
    logic cursor_lt_size;
    logic key_eq_min;
    logic found_r;
    logic found_s;
    logic min_eq;
    logic min_lt;
  } sts_t;

endpackage

`default_nettype wire

[design/msmj_chan_if.sv]
// Valid/ready channel carrying one payload item per transfer.
// Depends on msmj_pkg for the default payload type.
`default_nettype none

interface msmj_chan_if #(
  parameter type T = msmj_pkg::item_t
);
  logic valid;
  logic ready;
  T data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/msmj_ctrl.sv]
// Controller state machine of the sort-merge join: sequences loads, merge scans,
// group buffering and pair emission. Depends on msmj_pkg.
`default_nettype none

module msmj_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire msmj_pkg::sts_t sts,
  output msmj_pkg::cmd_t     cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_EXEC   = 14'b00000000000010,
    S_G_RD   = 14'b00000000000100,
    S_G_CHK  = 14'b00000000001000,
    S_G_EMIT = 14'b00000000010000,
    S_M_INIT = 14'b00000000100000,
    S_M_RD   = 14'b00000001000000,
    S_M_CHK  = 14'b00000010000000,
    S_DECIDE = 14'b00000100000000,
    S_K_RD   = 14'b00001000000000,
    S_K_CHK  = 14'b00010000000000,
    S_B_RD   = 14'b00100000000000,
    S_B_CHK  = 14'b01000000000000,
    S_FINISH = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic side, side_next;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE);

  // State, relation select and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side <= msmj_pkg::SIDE_R;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      side <= side_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    side_next = side;
    cmd = '0;
    cmd.side = side;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.mode)
          msmj_pkg::MODE_CLEAR: begin
            cmd.clear = 1'b1;
            state_next = S_FINISH;
          end
          msmj_pkg::MODE_LOAD_R: begin
            cmd.load_r = 1'b1;
            state_next = S_FINISH;
          end
          msmj_pkg::MODE_LOAD_S: begin
            cmd.load_s = 1'b1;
            state_next = S_FINISH;
          end
          default: begin
            side_next = msmj_pkg::SIDE_R;
            state_next = sts.group_active ? S_G_RD : S_M_INIT;
          end
        endcase
      end
      // Walk the R runs for a head that matches the buffered group.
      S_G_RD: begin
        if (sts.run_lt_n) begin
          cmd.rd_head = 1'b1;
          state_next = S_G_CHK;
        end else begin
          cmd.grp_end = 1'b1;
          state_next = S_M_INIT;
        end
      end
      S_G_CHK: begin
        if (sts.head_valid && sts.key_eq_group && sts.cursor_lt_size) begin
          cmd.grp_rd = 1'b1;
          state_next = S_G_EMIT;
        end else begin
          cmd.run_inc = 1'b1;
          state_next = S_G_RD;
        end
      end
      S_G_EMIT: begin
        cmd.emit_pair = 1'b1;
        state_next = S_FINISH;
      end
      // Least head key over R runs, then over S runs.
      S_M_INIT: begin
        cmd.min_init = 1'b1;
        cmd.run_rst = 1'b1;
        side_next = msmj_pkg::SIDE_R;
        state_next = S_M_RD;
      end
      S_M_RD: begin
        if (sts.run_lt_n) begin
          cmd.rd_head = 1'b1;
          state_next = S_M_CHK;
        end else if (side == msmj_pkg::SIDE_R) begin
          cmd.run_rst = 1'b1;
          side_next = msmj_pkg::SIDE_S;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_M_CHK: begin
        cmd.min_upd = 1'b1;
        cmd.run_inc = 1'b1;
        state_next = S_M_RD;
      end
      S_DECIDE: begin
        cmd.run_rst = 1'b1;
        if (!sts.found_r || !sts.found_s) begin
          cmd.res_done = 1'b1;
          state_next = S_FINISH;
        end else if (sts.min_eq) begin
          cmd.grp_start = 1'b1;
          side_next = msmj_pkg::SIDE_S;
          state_next = S_B_RD;
        end else begin
          side_next = sts.min_lt ? msmj_pkg::SIDE_R : msmj_pkg::SIDE_S;
          state_next = S_K_RD;
        end
      end
      // Skip the smaller key on one side.
      S_K_RD: begin
        if (sts.run_lt_n) begin
          cmd.rd_head = 1'b1;
          state_next = S_K_CHK;
        end else begin
          state_next = S_M_INIT;
        end
      end
      S_K_CHK: begin
        cmd.pos_inc = sts.head_valid && sts.key_eq_min;
        cmd.run_inc = 1'b1;
        state_next = S_K_RD;
      end
      // Buffer the S tuples with the matching key, up to GROUP_DEPTH of them.
      S_B_RD: begin
        if (sts.run_lt_n) begin
          cmd.rd_head = 1'b1;
          state_next = S_B_CHK;
        end else begin
          cmd.grp_set = 1'b1;
          side_next = msmj_pkg::SIDE_R;
          state_next = S_G_RD;
        end
      end
      S_B_CHK: begin
        if (sts.head_valid && sts.key_eq_min) begin
          cmd.grp_push = 1'b1;
          cmd.pos_inc = 1'b1;
        end else begin
          cmd.run_inc = 1'b1;
        end
        state_next = S_B_RD;
      end
      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/msmj_dp.sv]
// Datapath of the sort-merge join: tuple stores, run fills and positions,
// head compare, match group buffer and result registers. Depends on msmj_pkg.
`default_nettype none

module msmj_dp #(
  parameter int unsigned MAX_RUNS = 8,
  parameter int unsigned RUN_DEPTH = 64,
  parameter int unsigned GROUP_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire msmj_pkg::cmd_t    cmd,
  output msmj_pkg::sts_t         sts,
  input  wire msmj_pkg::item_t   item,
  output msmj_pkg::result_t      result,
  input  wire logic [3:0]        r_run_count,
  input  wire logic [3:0]        s_run_count
);

  localparam int unsigned RW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CW = $clog2(MAX_RUNS + 1);
  localparam int unsigned FW = $clog2(RUN_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = MAX_RUNS * RUN_DEPTH;
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned GW = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int unsigned GSW = $clog2(GROUP_DEPTH + 1);

  msmj_pkg::item_t item_q;
  msmj_pkg::tuple_t r_mem [STORE_DEPTH];
  msmj_pkg::tuple_t s_mem [STORE_DEPTH];
  msmj_pkg::tuple_t mg_mem [GROUP_DEPTH];
  msmj_pkg::tuple_t r_rd, s_rd, mg_rd, head;
  logic [FW-1:0] fill_r [MAX_RUNS];
  logic [FW-1:0] fill_s [MAX_RUNS];
  logic [FW-1:0] pos_r [MAX_RUNS];
  logic [FW-1:0] pos_s [MAX_RUNS];
  logic [CW-1:0] run_ctr;
  logic [CW-1:0] n_r, n_s, n_side;
  logic [RW-1:0] run_idx, ld_run;
  logic [FW-1:0] cur_pos, cur_fill, ld_fill;
  logic [AW:0] rd_addr, wr_addr;
  logic hv, hv_q;
  logic ld_ok_r, ld_ok_s, ld_base_ok;
  logic signed [31:0] least_r, least_s, side_least;
  logic found_r, found_s;
  logic [GSW-1:0] group_size, cursor, cursor_inc;
  logic signed [31:0] group_key;
  logic group_active;
  msmj_pkg::result_t pend, out_q;

  // Active run counts, limited to the number of runs built.
  assign n_r = (5'(r_run_count) > 5'(MAX_RUNS)) ? CW'(MAX_RUNS) : CW'(r_run_count);
  assign n_s = (5'(s_run_count) > 5'(MAX_RUNS)) ? CW'(MAX_RUNS) : CW'(s_run_count);
  assign n_side = cmd.side ? n_s : n_r;

  // Head of the selected run.
  assign run_idx = run_ctr[RW-1:0];
  assign cur_pos = cmd.side ? pos_s[run_idx] : pos_r[run_idx];
  assign cur_fill = cmd.side ? fill_s[run_idx] : fill_r[run_idx];
  assign hv = cur_pos < cur_fill;
  assign rd_addr = (AW+1)'(run_idx) * (AW+1)'(RUN_DEPTH) + (AW+1)'(cur_pos);
  assign head = cmd.side ? s_rd : r_rd;
  assign side_least = cmd.side ? least_s : least_r;

  // Load checks for the captured item.
  assign ld_run = RW'(item_q.run_index);
  assign ld_fill = (item_q.mode == msmj_pkg::MODE_LOAD_S) ? fill_s[ld_run] : fill_r[ld_run];
  assign ld_base_ok = (5'(item_q.run_index) < 5'(MAX_RUNS)) && (item_q.tuple_key != 32'sd0);
  assign ld_ok_r = ld_base_ok && (fill_r[ld_run] < FW'(RUN_DEPTH));
  assign ld_ok_s = ld_base_ok && (fill_s[ld_run] < FW'(RUN_DEPTH));
  assign wr_addr = (AW+1)'(ld_run) * (AW+1)'(RUN_DEPTH) + (AW+1)'(ld_fill);
  assign cursor_inc = cursor + GSW'(1);

  // Status towards the controller.
  always_comb begin
    sts.mode = item_q.mode;
    sts.group_active = group_active;
    sts.run_lt_n = run_ctr < n_side;
    sts.head_valid = hv_q;
    sts.key_eq_group = r_rd.key == group_key;
    sts.cursor_lt_size = cursor < group_size;
    sts.key_eq_min = head.key == side_least;
    sts.found_r = found_r;
    sts.found_s = found_s;
    sts.min_eq = least_r == least_s;
    sts.min_lt = least_r < least_s;
  end

  // Tuple stores: one write port for loads, one registered read port for heads.
  always_ff @(posedge clk) begin
    if (cmd.load_r && ld_ok_r) begin
      r_mem[wr_addr[AW-1:0]] <= '{key: item_q.tuple_key, val: item_q.tuple_payload};
    end
    if (cmd.rd_head && hv && !cmd.side) begin
      r_rd <= r_mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_s && ld_ok_s) begin
      s_mem[wr_addr[AW-1:0]] <= '{key: item_q.tuple_key, val: item_q.tuple_payload};
    end
    if (cmd.rd_head && hv && cmd.side) begin
      s_rd <= s_mem[rd_addr[AW-1:0]];
    end
  end

  // Match group buffer.
  always_ff @(posedge clk) begin
    if (cmd.grp_push && (group_size < GSW'(GROUP_DEPTH))) begin
      mg_mem[group_size[GW-1:0]] <= s_rd;
    end
    if (cmd.grp_rd) begin
      mg_rd <= mg_mem[cursor[GW-1:0]];
    end
  end

  // Item capture, head valid flag, least keys and results.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.rd_head) begin
      hv_q <= hv;
    end
    if (cmd.min_upd && hv_q) begin
      if (!cmd.side && (!found_r || head.key < least_r)) begin
        least_r <= head.key;
      end
      if (cmd.side && (!found_s || head.key < least_s)) begin
        least_s <= head.key;
      end
    end
    if (cmd.clear) begin
      pend <= '{status: msmj_pkg::ST_OK, default: '0};
    end
    if (cmd.load_r) begin
      pend <= '{status: ld_ok_r ? msmj_pkg::ST_OK : msmj_pkg::ST_REFUSED, default: '0};
    end
    if (cmd.load_s) begin
      pend <= '{status: ld_ok_s ? msmj_pkg::ST_OK : msmj_pkg::ST_REFUSED, default: '0};
    end
    if (cmd.res_done) begin
      pend <= '{status: msmj_pkg::ST_DONE, default: '0};
    end
    if (cmd.emit_pair) begin
      pend <= '{status: msmj_pkg::ST_PAIR, r_key: r_rd.key, r_value: r_rd.val,
                s_key: mg_rd.key, s_value: mg_rd.val};
    end
    if (cmd.out_load) begin
      out_q <= pend;
    end
  end

  // Fills, positions, run counter and group state.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
        fill_r[i] <= '0;
        fill_s[i] <= '0;
        pos_r[i] <= '0;
        pos_s[i] <= '0;
      end
      run_ctr <= '0;
      found_r <= 1'b0;
      found_s <= 1'b0;
      group_size <= '0;
      cursor <= '0;
      group_key <= '0;
      group_active <= 1'b0;
    end else begin
      if (cmd.load_r && ld_ok_r) begin
        fill_r[ld_run] <= fill_r[ld_run] + FW'(1);
      end
      if (cmd.load_s && ld_ok_s) begin
        fill_s[ld_run] <= fill_s[ld_run] + FW'(1);
      end
      if (cmd.pos_inc) begin
        if (cmd.side) begin
          pos_s[run_idx] <= pos_s[run_idx] + FW'(1);
        end else begin
          pos_r[run_idx] <= pos_r[run_idx] + FW'(1);
        end
      end
      if (cmd.emit_pair) begin
        if (cursor_inc >= group_size) begin
          cursor <= '0;
          pos_r[run_idx] <= pos_r[run_idx] + FW'(1);
        end else begin
          cursor <= cursor_inc;
        end
      end
      if (cmd.run_rst || cmd.grp_set) begin
        run_ctr <= '0;
      end else if (cmd.run_inc) begin
        run_ctr <= run_ctr + CW'(1);
      end
      if (cmd.min_init) begin
        found_r <= 1'b0;
        found_s <= 1'b0;
      end else if (cmd.min_upd && hv_q) begin
        if (cmd.side) begin
          found_s <= 1'b1;
        end else begin
          found_r <= 1'b1;
        end
      end
      if (cmd.grp_start) begin
        group_size <= '0;
      end else if (cmd.grp_push && (group_size < GSW'(GROUP_DEPTH))) begin
        group_size <= group_size + GSW'(1);
      end
      if (cmd.grp_set) begin
        group_key <= least_s;
        group_active <= 1'b1;
        cursor <= '0;
      end
      if (cmd.grp_end) begin
        group_active <= 1'b0;
        cursor <= '0;
      end
    end
  end

  assign result = out_q;

endmodule

`default_nettype wire

[design/multiway_sort_merge_join.sv]
// Top level of the multiway sort-merge join: channels, configuration port and
// the controller and datapath. Depends on msmj_pkg, msmj_chan_if, msmj_ctrl, msmj_dp.
`default_nettype none

// Equi-join of relations R and S held as sorted runs. Each item is a clear, a
// tuple load into a run, or a pull that yields one joined pair or a done report.
// One item is worked on at a time. A clear or load goes from transfer in
// through the execute and finish states to the result. A pull reads one run
// head at a time: every merge step scans all active run heads of both
// relations through the one registered read port of each tuple store. Each head
// skipped and each S tuple buffered takes a read and a check. A pair from a
// buffered group comes from R run heads read in turn. A result waits in the
// output register while the next item is taken in. Configuration is written
// through an APB-style port: r_run_count at byte address 0, s_run_count at 4.
module multiway_sort_merge_join #(
  parameter int unsigned MAX_RUNS = 8,
  parameter int unsigned RUN_DEPTH = 64,
  parameter int unsigned GROUP_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  msmj_chan_if.sink                              items,
  msmj_chan_if.source                            results,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [msmj_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [3:0] r_run_count, s_run_count;
  msmj_pkg::cmd_t cmd;
  msmj_pkg::sts_t sts;

  // Configuration registers; a write lands on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_run_count <= 4'd1;
      s_run_count <= 4'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr == msmj_pkg::ADDR_R_RUN_COUNT) begin
        r_run_count <= pwdata[3:0];
      end
      if (paddr == msmj_pkg::ADDR_S_RUN_COUNT) begin
        s_run_count <= pwdata[3:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == msmj_pkg::ADDR_S_RUN_COUNT) ? {28'd0, s_run_count}
                                                        : {28'd0, r_run_count};

  msmj_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msmj_dp #(
    .MAX_RUNS    (MAX_RUNS),
    .RUN_DEPTH   (RUN_DEPTH),
    .GROUP_DEPTH (GROUP_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item        (items.data),
    .result      (results.data),
    .r_run_count (r_run_count),
    .s_run_count (s_run_count)
  );

endmodule

`default_nettype wire
